// ----- sv/cdll_pkg.sv -----
// Package with shared constants, types and command codes of the linked list engine.
`default_nettype none
package cdll_pkg;
   localparam int unsigned PoolDepth = 16;
   localparam int unsigned IdxW      = $clog2(PoolDepth);
   localparam int unsigned CntW      = $clog2(PoolDepth + 1);

   typedef logic [IdxW-1:0] idx_type;
   typedef logic [CntW-1:0] cnt_type;

   typedef enum logic [3:0] {
      CMD_INS_FRONT  = 4'd0,
      CMD_INS_BACK   = 4'd1,
      CMD_INS_BEFORE = 4'd2,
      CMD_INS_AFTER  = 4'd3,
      CMD_DEL_FRONT  = 4'd4,
      CMD_DEL_BACK   = 4'd5,
      CMD_DEL_KEY    = 4'd6,
      CMD_COUNT      = 4'd7,
      CMD_LIST       = 4'd8,
      CMD_LIST_REV   = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Word that walks down the chain of search cells.
   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      idx_type     node;
      cnt_type     steps;
   } probe_type;
endpackage
`default_nettype wire

// ----- sv/cdll_cell.sv -----
// One search cell: compares the probe against one visited node and hands it on.
`default_nettype none
module cdll_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cdll_pkg::probe_type probe_in,
   input  wire logic [31:0]        node_value,
   input  wire cdll_pkg::idx_type  node_next,
   input  wire cdll_pkg::cnt_type  list_size,
   output cdll_pkg::probe_type     probe_out,
   output logic                    hit,
   output logic                    miss
);
   cdll_pkg::probe_type probe_ff;
   cdll_pkg::probe_type probe_in_w;

   // A match or the last node ends the walk; otherwise the probe moves to the next node.
   always_comb begin
      hit        = probe_in.valid && (node_value == probe_in.key);
      miss       = probe_in.valid && !hit &&
                   (probe_in.steps + cdll_pkg::cnt_type'(1) >= list_size);
      probe_in_w       = probe_in;
      probe_in_w.valid = probe_in.valid && !hit && !miss;
      probe_in_w.node  = node_next;
      probe_in_w.steps = probe_in.steps + cdll_pkg::cnt_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in_w.valid;
      end
      probe_ff.key   <= probe_in_w.key;
      probe_ff.node  <= probe_in_w.node;
      probe_ff.steps <= probe_in_w.steps;
   end

   assign probe_out = probe_ff;
endmodule
`default_nettype wire

// ----- sv/circular_doubly_linked_list_engine.sv -----
// Top level of the circular doubly linked list engine.
// Simple commands pass through the apply and response states before their word is presented.
// Key commands walk one node per cycle through a chain of search cells.
// Listing passes through the apply state, then presents one word per cycle as taken.
// One command is processed at a time; the next is accepted once its last word has been taken.
// Synchronous active-high reset empties the list; node contents stay undefined until written.
`default_nettype none
module circular_doubly_linked_list_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_command,
   input  wire logic [31:0] req_value,
   input  wire logic [31:0] req_key,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_element,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_node_count,
   output logic             rsp_last
);
   localparam int unsigned Depth = cdll_pkg::PoolDepth;

   typedef enum logic [2:0] {
      S_IDLE, S_SEARCH, S_APPLY, S_LIST, S_RESP
   } state_type;

   state_type state_ff;
   logic [31:0] node_data_ff [Depth];
   cdll_pkg::idx_type next_ff [Depth];
   cdll_pkg::idx_type prev_ff [Depth];
   logic [Depth-1:0] in_use_ff;
   cdll_pkg::idx_type head_ff;
   cdll_pkg::cnt_type size_ff;

   logic [3:0]  cmd_ff;
   logic [31:0] value_ff;
   cdll_pkg::idx_type target_ff;
   logic found_ff;
   cdll_pkg::idx_type walk_ff;
   cdll_pkg::cnt_type left_ff;

   logic        out_valid_ff;
   logic [31:0] out_elem_ff;
   logic [1:0]  out_status_ff;
   cdll_pkg::cnt_type out_count_ff;
   logic        out_last_ff;

   // Lowest free slot.
   cdll_pkg::idx_type free_idx;
   logic pool_full;
   always_comb begin
      free_idx  = '0;
      pool_full = 1'b1;
      for (int i = Depth - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_idx  = cdll_pkg::idx_type'(i);
            pool_full = 1'b0;
         end
      end
   end

   // Chain of search cells; cell k looks at the k-th node from the head.
   cdll_pkg::probe_type chain [Depth+1];
   logic [Depth-1:0] hits;
   logic [Depth-1:0] misses;
   cdll_pkg::probe_type start_probe;

   always_comb begin
      start_probe       = '0;
      start_probe.valid = (state_ff == S_IDLE) && req_valid && req_ready &&
                          (req_command == cdll_pkg::CMD_INS_BEFORE ||
                           req_command == cdll_pkg::CMD_INS_AFTER ||
                           req_command == cdll_pkg::CMD_DEL_KEY) &&
                          size_ff != '0 &&
                          !(pool_full && req_command != cdll_pkg::CMD_DEL_KEY);
      start_probe.key   = req_key;
      start_probe.node  = head_ff;
      start_probe.steps = '0;
   end
   assign chain[0] = start_probe;

   for (genvar g = 0; g < Depth; g++) begin : g_cell
      cdll_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .probe_in   (chain[g]),
         .node_value (node_data_ff[chain[g].node]),
         .node_next  (next_ff[chain[g].node]),
         .list_size  (size_ff),
         .probe_out  (chain[g+1]),
         .hit        (hits[g]),
         .miss       (misses[g])
      );
   end

   // Selected hit node.
   cdll_pkg::idx_type hit_node;
   always_comb begin
      hit_node = '0;
      for (int i = 0; i < Depth; i++) begin
         if (hits[i]) hit_node = chain[i].node;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !out_valid_ff;
   logic out_free;
   assign out_free = !out_valid_ff || rsp_ready;

   // The output register is loaded with a single word or with the next listed node.
   logic out_load;
   assign out_load = (state_ff == S_RESP) || (state_ff == S_LIST && out_free);

   // Control, list state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_use_ff    <= '0;
         head_ff      <= '0;
         size_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  cmd_ff    <= req_command;
                  value_ff  <= req_value;
                  // The head node is compared in the cycle of acceptance.
                  found_ff  <= |hits;
                  target_ff <= hit_node;
                  if (start_probe.valid && !(|hits) && !(|misses)) begin
                     state_ff <= S_SEARCH;
                  end else begin
                     state_ff <= S_APPLY;
                  end
               end
            end
            S_SEARCH: begin
               if (|hits) begin
                  found_ff  <= 1'b1;
                  target_ff <= hit_node;
                  state_ff  <= S_APPLY;
               end else if (|misses) begin
                  state_ff  <= S_APPLY;
               end
            end
            S_APPLY: begin
               // Apply the command and register its single word, or start listing.
               out_last_ff <= 1'b1;
               if (cmd_ff <= cdll_pkg::CMD_INS_AFTER) begin
                  state_ff    <= S_RESP;
                  out_elem_ff <= value_ff;
                  if (pool_full) begin
                     out_status_ff <= cdll_pkg::ST_FULL;
                     out_count_ff  <= size_ff;
                  end else if (size_ff == '0) begin
                     node_data_ff[free_idx] <= value_ff;
                     in_use_ff[free_idx]    <= 1'b1;
                     next_ff[free_idx]      <= free_idx;
                     prev_ff[free_idx]      <= free_idx;
                     head_ff                <= free_idx;
                     size_ff                <= cdll_pkg::cnt_type'(1);
                     out_status_ff          <= cdll_pkg::ST_OK;
                     out_count_ff           <= cdll_pkg::cnt_type'(1);
                  end else if (cmd_ff >= cdll_pkg::CMD_INS_BEFORE && !found_ff) begin
                     out_status_ff <= cdll_pkg::ST_NOT_FOUND;
                     out_count_ff  <= size_ff;
                  end else begin
                     // t is the node placed after the new one.
                     automatic cdll_pkg::idx_type t, p;
                     t = head_ff;
                     if (cmd_ff == cdll_pkg::CMD_INS_BEFORE) t = target_ff;
                     if (cmd_ff == cdll_pkg::CMD_INS_AFTER) t = next_ff[target_ff];
                     p = prev_ff[t];
                     node_data_ff[free_idx] <= value_ff;
                     in_use_ff[free_idx]    <= 1'b1;
                     next_ff[p]             <= free_idx;
                     prev_ff[free_idx]      <= p;
                     next_ff[free_idx]      <= t;
                     prev_ff[t]             <= free_idx;
                     if (cmd_ff == cdll_pkg::CMD_INS_FRONT) head_ff <= free_idx;
                     size_ff       <= size_ff + cdll_pkg::cnt_type'(1);
                     out_status_ff <= cdll_pkg::ST_OK;
                     out_count_ff  <= size_ff + cdll_pkg::cnt_type'(1);
                  end
               end else if (cmd_ff <= cdll_pkg::CMD_DEL_KEY) begin
                  automatic cdll_pkg::idx_type n, p, q;
                  n = head_ff;
                  if (cmd_ff == cdll_pkg::CMD_DEL_BACK) n = prev_ff[head_ff];
                  if (cmd_ff == cdll_pkg::CMD_DEL_KEY) n = target_ff;
                  p = prev_ff[n];
                  q = next_ff[n];
                  state_ff <= S_RESP;
                  if (size_ff == '0) begin
                     out_elem_ff   <= '0;
                     out_status_ff <= cdll_pkg::ST_EMPTY;
                     out_count_ff  <= size_ff;
                  end else if (cmd_ff == cdll_pkg::CMD_DEL_KEY && !found_ff) begin
                     out_elem_ff   <= '0;
                     out_status_ff <= cdll_pkg::ST_NOT_FOUND;
                     out_count_ff  <= size_ff;
                  end else begin
                     out_elem_ff   <= node_data_ff[n];
                     out_status_ff <= cdll_pkg::ST_OK;
                     in_use_ff[n]  <= 1'b0;
                     if (size_ff <= cdll_pkg::cnt_type'(1)) begin
                        size_ff      <= '0;
                        head_ff      <= '0;
                        out_count_ff <= '0;
                     end else begin
                        next_ff[p] <= q;
                        prev_ff[q] <= p;
                        if (n == head_ff) head_ff <= q;
                        size_ff      <= size_ff - cdll_pkg::cnt_type'(1);
                        out_count_ff <= size_ff - cdll_pkg::cnt_type'(1);
                     end
                  end
               end else begin
                  out_elem_ff   <= '0;
                  out_count_ff  <= size_ff;
                  if ((cmd_ff == cdll_pkg::CMD_COUNT || cmd_ff == cdll_pkg::CMD_LIST ||
                       cmd_ff == cdll_pkg::CMD_LIST_REV) && size_ff == '0) begin
                     out_status_ff <= cdll_pkg::ST_EMPTY;
                     state_ff      <= S_RESP;
                  end else if (cmd_ff == cdll_pkg::CMD_LIST ||
                               cmd_ff == cdll_pkg::CMD_LIST_REV) begin
                     out_status_ff <= cdll_pkg::ST_OK;
                     walk_ff  <= (cmd_ff == cdll_pkg::CMD_LIST) ? head_ff : prev_ff[head_ff];
                     left_ff  <= size_ff;
                     state_ff <= S_LIST;
                  end else begin
                     out_status_ff <= cdll_pkg::ST_OK;
                     state_ff      <= S_RESP;
                  end
               end
            end
            S_LIST: begin
               // One listed node per taken word.
               if (out_free) begin
                  out_elem_ff   <= node_data_ff[walk_ff];
                  out_status_ff <= cdll_pkg::ST_OK;
                  out_count_ff  <= size_ff;
                  out_last_ff   <= (left_ff == cdll_pkg::cnt_type'(1));
                  walk_ff       <= (cmd_ff == cdll_pkg::CMD_LIST) ? next_ff[walk_ff]
                                                                 : prev_ff[walk_ff];
                  left_ff       <= left_ff - cdll_pkg::cnt_type'(1);
                  if (left_ff == cdll_pkg::cnt_type'(1)) state_ff <= S_IDLE;
               end
            end
            S_RESP: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_element    = out_elem_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_node_count = out_count_ff;
   assign rsp_last       = out_last_ff;

   logic unused_ok;
   assign unused_ok = ^chain[Depth];

   // The list size never exceeds the pool depth.
   assert property (@(posedge clock) disable iff (reset)
      size_ff <= cdll_pkg::cnt_type'(Depth))
      else $error("list size beyond pool depth");
   // Number of slots in use matches the list size.
   assert property (@(posedge clock) disable iff (reset)
      $countones(in_use_ff) == 32'(size_ff))
      else $error("slot use and list size disagree");
   // No input accepted while a word is pending.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !out_valid_ff && state_ff == S_IDLE)
      else $error("ready while busy");
endmodule
`default_nettype wire

// ----- dv/circular_doubly_linked_list_engine_tb.sv -----
// Testbench for the circular doubly linked list engine: directed and random commands checked against a predictor.
`default_nettype none
module circular_doubly_linked_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = cdll_pkg::PoolDepth;
   localparam int StallLimit = 4000;

   typedef struct {
      logic [3:0]  command;
      logic [31:0] value;
      logic [31:0] key;
   } cmd_word_type;

   typedef struct {
      logic [31:0] element;
      logic [1:0]  status;
      logic [4:0]  node_count;
      logic        last;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_command = '0;
   logic [31:0] req_value = '0;
   logic [31:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_element;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_node_count;
   logic        rsp_last;

   circular_doubly_linked_list_engine u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_value(req_value), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_element(rsp_element),
      .rsp_status(rsp_status), .rsp_node_count(rsp_node_count), .rsp_last(rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the list.
   logic [31:0] shadow_data [Depth];
   logic [3:0]  shadow_next [Depth];
   logic [3:0]  shadow_prev [Depth];
   logic        shadow_used [Depth];
   logic [3:0]  shadow_head;
   int          shadow_size;

   cmd_word_type pending_cmds[$];
   rsp_word_type expected_rsps[$];
   int  mismatches = 0;
   bit  hold_rsp = 1'b0;

   function automatic int free_slot();
      for (int i = 0; i < Depth; i++) if (!shadow_used[i]) return i;
      return Depth;
   endfunction

   function automatic int search_key(logic [31:0] key);
      int n;
      n = shadow_head;
      for (int i = 0; i < shadow_size; i++) begin
         if (shadow_data[n] == key) return n;
         n = shadow_next[n];
      end
      return Depth;
   endfunction

   function automatic void push_rsp(logic [31:0] e, cdll_pkg::status_type s);
      rsp_word_type r;
      r.element = e; r.status = s; r.node_count = 5'(shadow_size); r.last = 1'b0;
      expected_rsps.push_back(r);
   endfunction

   // Apply one command to the shadow list and queue its expected words.
   function automatic void predict_list_op(cmd_word_type c);
      int n, t, p, q;
      cdll_pkg::status_type st;
      logic [31:0] e;
      st = cdll_pkg::ST_OK; e = '0;
      if (c.command <= cdll_pkg::CMD_INS_AFTER) begin
         n = free_slot();
         if (n >= Depth) st = cdll_pkg::ST_FULL;
         else if (shadow_size == 0) begin
            shadow_data[n] = c.value; shadow_used[n] = 1'b1;
            shadow_next[n] = 4'(n); shadow_prev[n] = 4'(n);
            shadow_head = 4'(n); shadow_size = 1;
         end else begin
            t = shadow_head;
            if (c.command >= cdll_pkg::CMD_INS_BEFORE) begin
               t = search_key(c.key);
               if (t >= Depth) st = cdll_pkg::ST_NOT_FOUND;
               else if (c.command == cdll_pkg::CMD_INS_AFTER) t = shadow_next[t];
            end
            if (st == cdll_pkg::ST_OK) begin
               shadow_data[n] = c.value; shadow_used[n] = 1'b1;
               p = shadow_prev[t];
               shadow_next[p] = 4'(n); shadow_prev[n] = 4'(p);
               shadow_next[n] = 4'(t); shadow_prev[t] = 4'(n);
               if (c.command == cdll_pkg::CMD_INS_FRONT) shadow_head = 4'(n);
               shadow_size++;
            end
         end
         push_rsp(c.value, st);
      end else if (c.command <= cdll_pkg::CMD_DEL_KEY) begin
         if (shadow_size == 0) st = cdll_pkg::ST_EMPTY;
         else begin
            if (c.command == cdll_pkg::CMD_DEL_FRONT) n = shadow_head;
            else if (c.command == cdll_pkg::CMD_DEL_BACK) n = shadow_prev[shadow_head];
            else n = search_key(c.key);
            if (n >= Depth) st = cdll_pkg::ST_NOT_FOUND;
            else begin
               e = shadow_data[n];
               shadow_used[n] = 1'b0;
               if (shadow_size <= 1) begin
                  shadow_size = 0; shadow_head = '0;
               end else begin
                  p = shadow_prev[n]; q = shadow_next[n];
                  shadow_next[p] = 4'(q); shadow_prev[q] = 4'(p);
                  if (n == shadow_head) shadow_head = 4'(q);
                  shadow_size--;
               end
            end
         end
         push_rsp(e, st);
      end else if (c.command == cdll_pkg::CMD_COUNT) begin
         push_rsp('0, shadow_size == 0 ? cdll_pkg::ST_EMPTY : cdll_pkg::ST_OK);
      end else if (c.command <= cdll_pkg::CMD_LIST_REV) begin
         if (shadow_size == 0) push_rsp('0, cdll_pkg::ST_EMPTY);
         else begin
            n = (c.command == cdll_pkg::CMD_LIST) ? shadow_head : shadow_prev[shadow_head];
            for (int i = 0; i < shadow_size; i++) begin
               push_rsp(shadow_data[n], cdll_pkg::ST_OK);
               n = (c.command == cdll_pkg::CMD_LIST) ? shadow_next[n] : shadow_prev[n];
            end
         end
      end else begin
         push_rsp('0, cdll_pkg::ST_OK);
      end
      expected_rsps[$].last = 1'b1;
   endfunction

   // Values are drawn from a small set so keys hit often, with some full-range noise.
   function automatic logic [31:0] pick_data();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom();
         default: return 32'($urandom_range(0, 7));
      endcase
   endfunction

   task automatic add_cmd(logic [3:0] cmd, logic [31:0] v, logic [31:0] k);
      cmd_word_type c;
      c.command = cmd; c.value = v; c.key = k;
      pending_cmds.push_back(c);
   endtask

   // Driver: random gap per word, payload held until accepted.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_cmds.size() > 0) begin
         req_valid   <= 1'b1;
         req_command <= pending_cmds[0].command;
         req_value   <= pending_cmds[0].value;
         req_key     <= pending_cmds[0].key;
         predict_list_op(pending_cmds.pop_front());
         send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Monitor: random stall per word, plus one long hold-off.
   int recv_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected word: element %h", rsp_element);
            end else begin
               if (rsp_element !== expected_rsps[0].element
                   || rsp_status !== expected_rsps[0].status
                   || rsp_node_count !== expected_rsps[0].node_count
                   || rsp_last !== expected_rsps[0].last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                        expected_rsps[0].element, expected_rsps[0].status,
                        expected_rsps[0].node_count, expected_rsps[0].last,
                        rsp_element, rsp_status, rsp_node_count, rsp_last);
               end
               void'(expected_rsps.pop_front());
            end
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (rsp_ready && rsp_valid) begin
            recv_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            rsp_ready <= (recv_wait == 0);
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= (recv_wait == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off while the sender keeps offering.
   initial begin
      int cnt;
      cnt = 0;
      @(negedge reset);
      repeat (1000) @(posedge clock);
      hold_rsp = 1'b1;
      while (cnt < 300) begin
         @(posedge clock);
         cnt++;
      end
      hold_rsp = 1'b0;
   end

   // Watchdog on cycles without any accepted word.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      int op;
      logic [31:0] k;
      for (int i = 0; i < Depth; i++) begin
         shadow_data[i] = '0; shadow_next[i] = '0; shadow_prev[i] = '0; shadow_used[i] = 1'b0;
      end
      shadow_head = '0; shadow_size = 0;
      // Directed: empty-list cases, extremes, full pool, key misses.
      add_cmd(cdll_pkg::CMD_DEL_FRONT, '0, '0);
      add_cmd(cdll_pkg::CMD_DEL_KEY, '0, '0);
      add_cmd(cdll_pkg::CMD_COUNT, '0, '0);
      add_cmd(cdll_pkg::CMD_LIST, '0, '0);
      add_cmd(cdll_pkg::CMD_LIST_REV, '0, '0);
      add_cmd(cdll_pkg::CMD_INS_BEFORE, 32'h8000_0000, 32'h1234);
      add_cmd(cdll_pkg::CMD_DEL_KEY, '0, 32'h5);
      add_cmd(cdll_pkg::CMD_DEL_KEY, '0, 32'h8000_0000);
      add_cmd(cdll_pkg::CMD_INS_AFTER, 32'h7fff_ffff, 32'hffff_ffff);
      add_cmd(cdll_pkg::CMD_INS_BEFORE, 32'hffff_ffff, 32'h7fff_ffff);
      add_cmd(cdll_pkg::CMD_INS_AFTER, 32'h1, 32'h9);
      add_cmd(4'd15, 32'hffff_ffff, 32'hffff_ffff);
      add_cmd(4'd10, '0, '0);
      for (int i = 0; i < 15; i++)
         add_cmd(i[0] ? cdll_pkg::CMD_INS_BACK : cdll_pkg::CMD_INS_FRONT, i, '0);
      add_cmd(cdll_pkg::CMD_INS_FRONT, 32'h55, '0);
      add_cmd(cdll_pkg::CMD_LIST, '0, '0);
      add_cmd(cdll_pkg::CMD_LIST_REV, '0, '0);
      add_cmd(cdll_pkg::CMD_DEL_BACK, '0, '0);
      add_cmd(cdll_pkg::CMD_DEL_FRONT, '0, '0);
      add_cmd(cdll_pkg::CMD_COUNT, '0, '0);
      // Random commands weighted toward inserts and key hits.
      for (int i = 0; i < 336; i++) begin
         op = $urandom_range(0, 19);
         k = pick_data();
         if (op < 6) add_cmd(4'(op % 4), pick_data(), k);
         else if (op < 12) add_cmd(4'(4 + op % 3), pick_data(), k);
         else if (op < 13) add_cmd(cdll_pkg::CMD_COUNT, $urandom(), $urandom());
         else if (op < 17)
            add_cmd(op[0] ? cdll_pkg::CMD_LIST : cdll_pkg::CMD_LIST_REV, $urandom(), $urandom());
         else if (op < 18) add_cmd(4'($urandom_range(10, 15)), $urandom(), $urandom());
         else add_cmd(4'($urandom_range(0, 3)), pick_data(), k);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_cmds.size() == 0);
      while (expected_rsps.size() > 0 || req_valid) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
